// File: hdl/fifo_queue_with_delete_by_value_defines.svh
// ----------------------------------------------------------------------------
// fifo queue with delete by value: assertion macros
// Clocked assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_DELETE_BY_VALUE_DEFINES_SVH
`define FIFO_QUEUE_WITH_DELETE_BY_VALUE_DEFINES_SVH

`ifndef SYNTHESIS

// assertion with reset disable
`define FQD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fqd assertion failed");

// assertion without reset disable
`define FQD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fqd assertion failed");

`else

`define FQD_ASSERT(lbl, clk, rst_n, prop)
`define FQD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: hdl/fqd_pkg.sv
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types and constants of the fifo queue with delete by value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fqd_pkg;

    // default capacity of the queue
    localparam int QUEUE_DEPTH_DEF = 16;

    // fixed field widths
    localparam int VAL_W = 32;
    localparam int OCC_W = 5;

    // operation codes
    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_DELETE  = 2'd2
    } t_op;

    // status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_DEQ   = 2'd1,
        S_SCAN  = 2'd2,
        S_SHIFT = 2'd3
    } t_state;

    // completion of one word, sequencer to output stage
    typedef struct packed {
        logic             valid;
        t_status          status;
        logic             take_rd;
        logic [OCC_W-1:0] occ;
    } t_done;

endpackage

`default_nettype wire

// File: hdl/fifo_queue_with_delete_by_value.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_by_value
// Fifo of signed words with dequeue at the head, enqueue at the tail and
// removal of the first entry that equals a given word.
// ----------------------------------------------------------------------------
// Issue a word by holding start high while busy is low; it is taken at that
// edge. Every word gives exactly one result, shown for a single cycle with
// o_done high; it cannot be held off, so sample it when o_done is seen. The
// result is registered and appears in the cycle after the last working cycle.
// Enqueue, a refused enqueue, an operation on an empty queue and the unused
// code complete in the cycle they are issued and busy stays low. Dequeue
// passes through S_DEQ. Delete walks every entry whether or not a match is
// found: the entry store has a single read port, so the search and the
// compaction of the entries behind the match walk it one entry per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_queue_with_delete_by_value_defines.svh"

module fifo_queue_with_delete_by_value #(
    parameter int QUEUE_DEPTH = fqd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        i_operation,
    input  wire logic signed [fqd_pkg::VAL_W-1:0]  i_value,
    output logic                                   o_done,
    output logic signed [fqd_pkg::VAL_W-1:0]       o_result_value,
    output logic [1:0]                             o_status,
    output logic [fqd_pkg::OCC_W-1:0]              o_occupancy
);
    import fqd_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [VAL_W-1:0] w_wdata;
    logic [AW-1:0]    w_raddr;
    logic [VAL_W-1:0] w_rdata;
    t_done            w_done;

    logic             r_done;
    logic [VAL_W-1:0] r_result, n_result;
    t_status          r_status;
    logic [OCC_W-1:0] r_occ;

    // sequencer
    fqd_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_rdata     (w_rdata),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .o_done      (w_done)
    );

    // entry store
    fqd_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // removed word only on a dequeue
    assign n_result = w_done.take_rd ? w_rdata : '0;

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_done.valid;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (w_done.valid) begin
            r_result <= n_result;
            r_status <= w_done.status;
            r_occ    <= w_done.occ;
        end
    end

    assign o_done         = r_done;
    assign o_result_value = r_result;
    assign o_status       = r_status;
    assign o_occupancy    = r_occ;

    // checks
    `FQD_ASSERT(a_full_at_depth, i_clk, i_rst_n, o_done && (o_status == ST_FULL) |-> (o_occupancy == OCC_W'(QUEUE_DEPTH)))
    `FQD_ASSERT(a_empty_zero, i_clk, i_rst_n, o_done && (o_status == ST_EMPTY) |-> (o_occupancy == '0))
    `FQD_ASSERT(a_write_in_work, i_clk, i_rst_n, w_we |-> (start || busy))
    `FQD_ASSERT(a_idle_after_done, i_clk, i_rst_n, w_done.valid |=> !busy)

endmodule

`default_nettype wire

// File: hdl/fqd_ram.sv
// ----------------------------------------------------------------------------
// fqd_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fqd_ram #(
    parameter int QUEUE_DEPTH = fqd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]         i_waddr,
    input  wire logic [fqd_pkg::VAL_W-1:0]              i_wdata,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]         i_raddr,
    output logic      [fqd_pkg::VAL_W-1:0]              o_rdata
);
    import fqd_pkg::*;

    logic [VAL_W-1:0] r_mem [QUEUE_DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/fqd_ctrl.sv
// ----------------------------------------------------------------------------
// fqd_ctrl
// Sequencer: circular head pointer and count, search and compaction walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fqd_ctrl #(
    parameter int QUEUE_DEPTH = fqd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [1:0]                             i_operation,
    input  wire logic [fqd_pkg::VAL_W-1:0]              i_value,
    input  wire logic [fqd_pkg::VAL_W-1:0]              i_rdata,
    output logic                                        o_we,
    output logic      [$clog2(QUEUE_DEPTH)-1:0]         o_waddr,
    output logic      [fqd_pkg::VAL_W-1:0]              o_wdata,
    output logic      [$clog2(QUEUE_DEPTH)-1:0]         o_raddr,
    output fqd_pkg::t_done                              o_done
);
    import fqd_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head,  n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx,   n_idx;
    logic [VAL_W-1:0] r_val,  n_val;

    logic [CW-1:0]   w_idx_inc;
    logic [AW-1:0]   w_head_inc;
    logic            w_match;
    logic            w_last;
    logic            w_empty;
    logic            w_full;
    t_op             w_op;

    // logical position to memory address, one compare and subtract
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] lidx);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(lidx);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // shared conditions
    assign w_op       = t_op'(i_operation);
    assign w_idx_inc  = CW'(r_idx) + 1'b1;
    assign w_head_inc = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_match    = (i_rdata == r_val);
    assign w_last     = (w_idx_inc == r_count);
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CW'(QUEUE_DEPTH));
    assign busy       = (r_state != S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (w_op)
                        OP_DEQUEUE: if (!w_empty) n_state = S_DEQ;
                        OP_DELETE:  if (!w_empty) n_state = S_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_DEQ: n_state = S_IDLE;
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_IDLE;
                end else if (w_match) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_head         = r_head;
        n_count        = r_count;
        n_idx          = r_idx;
        n_val          = r_val;
        o_we           = 1'b0;
        o_waddr        = f_phys(r_head, r_count);
        o_wdata        = i_value;
        o_raddr        = r_head;
        o_done         = '0;
        o_done.status  = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (w_op)
                        OP_ENQUEUE: begin
                            o_done.valid = 1'b1;
                            if (w_full) begin
                                o_done.status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_DEQUEUE: begin
                            if (w_empty) begin
                                o_done.valid  = 1'b1;
                                o_done.status = ST_EMPTY;
                            end
                        end
                        OP_DELETE: begin
                            if (w_empty) begin
                                o_done.valid  = 1'b1;
                                o_done.status = ST_EMPTY;
                            end else begin
                                n_val = i_value;
                                n_idx = '0;
                            end
                        end
                        default: o_done.valid = 1'b1;
                    endcase
                end
            end
            // head word is on the read port
            S_DEQ: begin
                o_done.valid   = 1'b1;
                o_done.take_rd = 1'b1;
                n_head         = w_head_inc;
                n_count        = r_count - 1'b1;
            end
            // compare one entry a cycle, fetch the next one ahead
            S_SCAN: begin
                o_raddr = f_phys(r_head, w_idx_inc);
                if (w_match && w_last) begin
                    o_done.valid = 1'b1;
                    n_count      = r_count - 1'b1;
                end else if (w_last) begin
                    o_done.valid  = 1'b1;
                    o_done.status = ST_NOT_FOUND;
                end else begin
                    n_idx = w_idx_inc[AW-1:0];
                end
            end
            // move each later entry up by one place
            S_SHIFT: begin
                o_we    = 1'b1;
                o_waddr = f_phys(r_head, CW'(r_idx) - 1'b1);
                o_wdata = i_rdata;
                o_raddr = f_phys(r_head, w_idx_inc);
                if (w_last) begin
                    o_done.valid = 1'b1;
                    n_count      = r_count - 1'b1;
                end else begin
                    n_idx = w_idx_inc[AW-1:0];
                end
            end
            default: ;
        endcase
        o_done.occ = OCC_W'(n_count);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // search registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_val <= n_val;
    end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: fifo queue with delete by value
// Drives enqueue, dequeue, delete and unused-code words through the
// start/busy handshake in random bursts, predicts every result with a queue
// of its own and checks each o_done word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import fqd_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int RANDOM_WORDS = 1400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    // the operation code that the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one predicted result word
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        t_status                 status;
        logic [OCC_W-1:0]        occ;
    } t_outcome;

    // one row of the directed script
    typedef struct packed {
        logic [1:0]              op;
        logic [VAL_W-1:0]        word;
        logic [4:0]              reps;
        logic                    typed;
        logic signed [VAL_W-1:0] exp_value;
        t_status                 exp_status;
        logic [OCC_W-1:0]        exp_occ;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [1:0]              i_operation = OP_ENQUEUE;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    busy;
    logic                    o_done;
    logic signed [VAL_W-1:0] o_result_value;
    logic [1:0]              o_status;
    logic [OCC_W-1:0]        o_occupancy;

    // predictor state and results still to arrive
    logic signed [VAL_W-1:0] held_words[$];
    t_outcome                awaited_results[$];
    int                      mismatch_count = 0;
    int                      cycle_count = 0;
    int                      burst_left = 0;
    t_row                    script[15];

    fifo_queue_with_delete_by_value #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_operation(i_operation),
        .i_value(i_value),
        .o_done(o_done),
        .o_result_value(o_result_value),
        .o_status(o_status),
        .o_occupancy(o_occupancy)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("tb: mismatch on %s, got %0d, expected %0d, cycle %0d",
                 what, got, want, cycle_count);
    endtask

    // apply one word to the predicted queue and return its result
    function automatic t_outcome apply_queue_op(input logic [1:0] op,
                                                input logic signed [VAL_W-1:0] word);
        t_outcome res;
        int hit;
        res.value = '0;
        res.status = ST_OK;
        hit = -1;
        case (op)
            OP_ENQUEUE: begin
                if (held_words.size() >= DEPTH)
                    res.status = ST_FULL;
                else
                    held_words.push_back(word);
            end
            OP_DEQUEUE: begin
                if (held_words.size() == 0)
                    res.status = ST_EMPTY;
                else
                    res.value = held_words.pop_front();
            end
            OP_DELETE: begin
                if (held_words.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // first match from the head; later entries keep their order
                    for (int k = 0; k < held_words.size() && hit < 0; k++)
                        if (held_words[k] == word)
                            hit = k;
                    if (hit < 0)
                        res.status = ST_NOT_FOUND;
                    else
                        held_words.delete(hit);
                end
            end
            default: ;
        endcase
        res.occ = OCC_W'(held_words.size());
        return res;
    endfunction

    // send one word, with a random gap when the current burst is used up
    task automatic issue_word(input logic [1:0] op, input logic [VAL_W-1:0] word,
                              input bit typed, input t_outcome typed_out);
        t_outcome predicted;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        start <= 1'b1;
        i_operation <= op;
        i_value <= word;
        do @(posedge i_clk); while (busy);
        predicted = apply_queue_op(op, word);
        awaited_results.push_back(typed ? typed_out : predicted);
    endtask

    // hold the sender off until every result is in
    task automatic wait_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // random value, often from a small pool so that deletes find matches
    function automatic logic [VAL_W-1:0] pick_word();
        logic [VAL_W-1:0] pool[8];
        pool = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h1, 32'h7, 32'h5555_AAAA, 32'hFFFF_FF9C};
        if ($urandom_range(0, 9) < 6)
            return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch("result with nothing awaited", o_status, -1);
            end else begin
                want = awaited_results.pop_front();
                if (o_result_value !== want.value)
                    flag_mismatch("result_value", o_result_value, want.value);
                if (o_status !== want.status)
                    flag_mismatch("status", o_status, want.status);
                if (o_occupancy !== want.occ)
                    flag_mismatch("occupancy", o_occupancy, want.occ);
            end
        end
    end

    // stimulus
    initial begin
        t_outcome typed_out;
        logic [1:0] op;
        logic [VAL_W-1:0] word;
        int fill_bias;
        int episode_left;

        fill_bias = 50;
        episode_left = 0;

        // directed script: empty cases, extremes, matches, full queue
        script[0]  = '{OP_DEQUEUE, 32'h0,         5'd1,  1'b1, 32'h0, ST_EMPTY, 5'd0};
        script[1]  = '{OP_DELETE,  32'h5,         5'd1,  1'b1, 32'h0, ST_EMPTY, 5'd0};
        script[2]  = '{OP_UNUSED,  32'h0,         5'd1,  1'b1, 32'h0, ST_OK, 5'd0};
        script[3]  = '{OP_ENQUEUE, 32'h7FFF_FFFF, 5'd1,  1'b1, 32'h0, ST_OK, 5'd1};
        script[4]  = '{OP_ENQUEUE, 32'h8000_0000, 5'd1,  1'b1, 32'h0, ST_OK, 5'd2};
        script[5]  = '{OP_ENQUEUE, 32'hFFFF_FFFF, 5'd1,  1'b1, 32'h0, ST_OK, 5'd3};
        script[6]  = '{OP_ENQUEUE, 32'h0,         5'd1,  1'b1, 32'h0, ST_OK, 5'd4};
        script[7]  = '{OP_DELETE,  32'd12345,     5'd1,  1'b1, 32'h0, ST_NOT_FOUND, 5'd4};
        script[8]  = '{OP_DELETE,  32'hFFFF_FFFF, 5'd1,  1'b1, 32'h0, ST_OK, 5'd3};
        script[9]  = '{OP_DEQUEUE, 32'h0,         5'd1,  1'b1, 32'h7FFF_FFFF, ST_OK, 5'd2};
        // duplicate value: delete must take the one nearer the head
        script[10] = '{OP_ENQUEUE, 32'h8000_0000, 5'd1,  1'b0, 32'h0, ST_OK, 5'd0};
        script[11] = '{OP_DELETE,  32'h8000_0000, 5'd1,  1'b0, 32'h0, ST_OK, 5'd0};
        // fill to capacity, then a refused enqueue and a delete at the tail
        script[12] = '{OP_ENQUEUE, 32'h5555_5555, 5'd14, 1'b0, 32'h0, ST_OK, 5'd0};
        script[13] = '{OP_ENQUEUE, 32'hAAAA_AAAA, 5'd1,  1'b1, 32'h0, ST_FULL, 5'd16};
        script[14] = '{OP_DELETE,  32'h5555_5562, 5'd1,  1'b0, 32'h0, ST_OK, 5'd0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r]) begin
            for (int k = 0; k < script[r].reps; k++) begin
                typed_out = '{script[r].exp_value, script[r].exp_status, script[r].exp_occ};
                issue_word(script[r].op, script[r].word + k, script[r].typed, typed_out);
            end
        end

        // random part in episodes that lean towards filling or draining
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (episode_left == 0) begin
                case ($urandom_range(0, 2))
                    0: fill_bias = 85;
                    1: fill_bias = 50;
                    default: fill_bias = 15;
                endcase
                episode_left = $urandom_range(20, 80);
            end
            episode_left--;
            if (n == RANDOM_WORDS / 2 || $urandom_range(0, 199) == 0)
                wait_until_drained();

            word = pick_word();
            if ($urandom_range(0, 99) < 3)
                op = OP_UNUSED;
            else if ($urandom_range(0, 99) < fill_bias)
                op = OP_ENQUEUE;
            else if ($urandom_range(0, 1) == 0)
                op = OP_DEQUEUE;
            else
                op = OP_DELETE;
            // deletes mostly aim at a value that is held
            if (op == OP_DELETE && held_words.size() != 0 && $urandom_range(0, 3) != 0)
                word = held_words[$urandom_range(0, held_words.size() - 1)];
            issue_word(op, word, 1'b0, '0);
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
